>>> hw/rtl/sdi_pkg.sv
// Package for the SD-mode card identification sequencer.
// Holds the phase and code enums, command constants and channel payload types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package sdi_pkg;

  // Sequencer phases, in sequence order.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_LOOP55 = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD2   = 4'd5,
    PH_CMD3   = 4'd6,
    PH_CMD9   = 4'd7,
    PH_CMD7   = 4'd8,
    PH_APP55  = 4'd9,
    PH_ACMD6  = 4'd10,
    PH_DONE   = 4'd11,
    PH_FAIL   = 4'd12
  } phase_e;

  // What a result item tells the command engine to do.
  typedef enum logic [1:0] {
    ACT_ISSUE  = 2'd0,
    ACT_OK     = 2'd1,
    ACT_ERR    = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  // Expected response length of the issued command.
  typedef enum logic [1:0] {
    RESP_NONE  = 2'd0,
    RESP_SHORT = 2'd1,
    RESP_LONG  = 2'd2
  } resp_kind_e;

  // Card type codes.
  localparam logic [1:0] CARD_UNKNOWN = 2'd0;
  localparam logic [1:0] CARD_V1      = 2'd1;
  localparam logic [1:0] CARD_V2_SC   = 2'd2;
  localparam logic [1:0] CARD_V2_HC   = 2'd3;

  // Input mode codes.
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_OUTCOME = 1'b1;

  // Command indexes.
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_ALL_CID    = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
  localparam logic [5:0] CMD_SET_WIDTH  = 6'd6;
  localparam logic [5:0] CMD_SELECT     = 6'd7;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
  localparam logic [5:0] CMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;

  // Command arguments and response checks.
  localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
  localparam logic [31:0] HCS_ARG       = 32'h4000_0000;
  localparam logic [31:0] BUS_4BIT_ARG  = 32'h0000_0002;

  // Configuration register indexes and reset values.
  localparam int unsigned    CFG_IDX_W      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENT_DIV = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_DIV  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 8'd2;
  localparam logic [7:0]     IDENT_DIV_RST  = 8'd118;
  localparam logic [7:0]     FAST_DIV_RST   = 8'd1;
  localparam logic [7:0]     RETRY_LIM_RST  = 8'd200;

  // Input item.
  typedef struct packed {
    logic        mode;
    logic        cmd_failed;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
  } in_item_t;

  // Result item.
  typedef struct packed {
    action_e     action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    resp_kind_e  resp_kind;
    logic [1:0]  card_kind;
    logic [32:0] sector_total;
    logic [15:0] card_address;
    logic [7:0]  clock_divider;
    logic        wide_bus;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/sdi_if.sv
// Channel interfaces of the SD-mode identification sequencer.
// Item channels carry valid, ready and a payload; the config channel an index and value.
// Depends on sdi_pkg for the payload types.
`default_nettype none

interface sdi_in_if;
  logic             valid;
  logic             ready;
  sdi_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdi_out_if;
  logic              valid;
  logic              ready;
  sdi_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sdi_pkg::CFG_IDX_W-1:0]   index;
  logic [7:0]                      value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sd_card_init_sequencer.sv
// SD-mode card identification sequencer, top level.
// Depends on sdi_pkg and the channel interfaces in sdi_if.sv.
//
// Usage: send a start item (mode 0) on in_i to begin identification; the
// block answers with CMD0. After each command, send an outcome item (mode 1)
// with the failure flag and response words; the block answers with the next
// command (index, argument, response kind), finished-ok or finished-error.
// Outcome items while idle or finished are answered with the ignored action.
// Configuration writes on cfg_i are always taken (cfg_i.ready is high) and
// set the identification and fast clock dividers and the ACMD41 retry limit.
//
// Timing: every input transfer produces exactly one result transfer from
// the output register. One item per cycle is sustained unless out_i stalls;
// the phase update and CSD field extraction are combinational. The input
// side is ready whenever the output register is empty or being drained, so
// a stall on out_i holds the pending result and blocks new input transfers.
//
// Reset: rst_ni clears the phase to idle, all card state to zero, the
// output register to empty and the config registers to their defaults.
`default_nettype none

module sd_card_init_sequencer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdi_in_if.sink    in_i,
  sdi_out_if.source out_o,
  sdi_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [7:0] ident_div_q, fast_div_q, retry_lim_q;

  // Sequencer state.
  sdi_pkg::phase_e phase_q, phase_d;
  logic            v2_q, v2_d;
  logic [7:0]      attempt_q, attempt_d;
  logic [1:0]      card_type_q, card_type_d;
  logic [15:0]     rca_q, rca_d;
  logic [32:0]     sector_q, sector_d;
  logic            wide_q, wide_d;

  // Output register.
  logic               out_valid_q;
  sdi_pkg::out_item_t out_q, res_d;

  logic in_fire;
  logic active;
  sdi_pkg::action_e    act;
  logic [5:0]          idx;
  logic [31:0]         arg;
  sdi_pkg::resp_kind_e kind;
  logic [22:0]         csd_v2_size;
  logic [12:0]         csd_v1_size;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_div_q <= sdi_pkg::IDENT_DIV_RST;
      fast_div_q  <= sdi_pkg::FAST_DIV_RST;
      retry_lim_q <= sdi_pkg::RETRY_LIM_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sdi_pkg::CFG_IDENT_DIV: ident_div_q <= cfg_i.value;
        sdi_pkg::CFG_FAST_DIV:  fast_div_q  <= cfg_i.value;
        sdi_pkg::CFG_RETRY_LIM: retry_lim_q <= cfg_i.value;
        default: ;
      endcase
    end
  end

  // Capacity from the CSD: block count plus one, scaled to 512-byte sectors.
  assign csd_v2_size = {1'b0, in_i.data.resp_word2[5:0], in_i.data.resp_word3[31:16]}
                       + 23'd1;
  assign csd_v1_size = {1'b0, in_i.data.resp_word2[19:8]} + 13'd1;

  assign active = (phase_q inside {[sdi_pkg::PH_CMD0:sdi_pkg::PH_ACMD6]});

  // Phase transition and result for the item being transferred.
  always_comb begin
    phase_d     = phase_q;
    v2_d        = v2_q;
    attempt_d   = attempt_q;
    card_type_d = card_type_q;
    rca_d       = rca_q;
    sector_d    = sector_q;
    wide_d      = wide_q;
    act         = sdi_pkg::ACT_ISSUE;
    idx         = sdi_pkg::CMD_GO_IDLE;
    arg         = '0;
    kind        = sdi_pkg::RESP_NONE;

    if (in_i.data.mode == sdi_pkg::MODE_START) begin
      // A start always restarts the sequence from CMD0.
      card_type_d = sdi_pkg::CARD_UNKNOWN;
      sector_d    = '0;
      rca_d       = '0;
      wide_d      = 1'b0;
      v2_d        = 1'b0;
      attempt_d   = '0;
      phase_d     = sdi_pkg::PH_CMD0;
    end else if (!active) begin
      act = sdi_pkg::ACT_IGNORE;
    end else if (in_i.data.cmd_failed && phase_q != sdi_pkg::PH_CMD8) begin
      card_type_d = sdi_pkg::CARD_UNKNOWN;
      phase_d     = sdi_pkg::PH_FAIL;
      act         = sdi_pkg::ACT_ERR;
    end else begin
      unique case (phase_q)
        sdi_pkg::PH_CMD0: begin
          phase_d = sdi_pkg::PH_CMD8;
          idx     = sdi_pkg::CMD_IF_COND;
          arg     = sdi_pkg::IF_COND_ARG;
          kind    = sdi_pkg::RESP_SHORT;
        end
        sdi_pkg::PH_CMD8: begin
          // A failed or mismatched CMD8 selects the V1 path.
          v2_d      = !in_i.data.cmd_failed && (in_i.data.resp_word1 == sdi_pkg::IF_COND_ARG);
          attempt_d = '0;
          phase_d   = sdi_pkg::PH_LOOP55;
          idx       = sdi_pkg::CMD_APP;
          kind      = sdi_pkg::RESP_SHORT;
        end
        sdi_pkg::PH_LOOP55: begin
          phase_d = sdi_pkg::PH_ACMD41;
          idx     = sdi_pkg::CMD_OP_COND;
          arg     = v2_q ? sdi_pkg::HCS_ARG : '0;
          kind    = sdi_pkg::RESP_SHORT;
        end
        sdi_pkg::PH_ACMD41: begin
          if (attempt_q >= retry_lim_q) begin
            card_type_d = sdi_pkg::CARD_UNKNOWN;
            phase_d     = sdi_pkg::PH_FAIL;
            act         = sdi_pkg::ACT_ERR;
          end else begin
            attempt_d = attempt_q + 8'd1;
            if (!in_i.data.resp_word1[31]) begin
              // Card still busy: poll again.
              phase_d = sdi_pkg::PH_LOOP55;
              idx     = sdi_pkg::CMD_APP;
              kind    = sdi_pkg::RESP_SHORT;
            end else begin
              if (v2_q) begin
                card_type_d = in_i.data.resp_word1[30] ? sdi_pkg::CARD_V2_HC
                                                       : sdi_pkg::CARD_V2_SC;
              end else begin
                card_type_d = sdi_pkg::CARD_V1;
              end
              phase_d = sdi_pkg::PH_CMD2;
              idx     = sdi_pkg::CMD_ALL_CID;
              kind    = sdi_pkg::RESP_LONG;
            end
          end
        end
        sdi_pkg::PH_CMD2: begin
          phase_d = sdi_pkg::PH_CMD3;
          idx     = sdi_pkg::CMD_SEND_RCA;
          kind    = sdi_pkg::RESP_SHORT;
        end
        sdi_pkg::PH_CMD3: begin
          rca_d   = in_i.data.resp_word1[31:16];
          phase_d = sdi_pkg::PH_CMD9;
          idx     = sdi_pkg::CMD_SEND_CSD;
          arg     = {in_i.data.resp_word1[31:16], 16'h0000};
          kind    = sdi_pkg::RESP_LONG;
        end
        sdi_pkg::PH_CMD9: begin
          if (card_type_q == sdi_pkg::CARD_V2_SC || card_type_q == sdi_pkg::CARD_V2_HC) begin
            sector_d = {csd_v2_size, 10'b0};
          end else begin
            sector_d = {14'b0, csd_v1_size, 6'b0};
          end
          phase_d = sdi_pkg::PH_CMD7;
          idx     = sdi_pkg::CMD_SELECT;
          arg     = {rca_q, 16'h0000};
          kind    = sdi_pkg::RESP_SHORT;
        end
        sdi_pkg::PH_CMD7: begin
          phase_d = sdi_pkg::PH_APP55;
          idx     = sdi_pkg::CMD_APP;
          arg     = {rca_q, 16'h0000};
          kind    = sdi_pkg::RESP_SHORT;
        end
        sdi_pkg::PH_APP55: begin
          phase_d = sdi_pkg::PH_ACMD6;
          idx     = sdi_pkg::CMD_SET_WIDTH;
          arg     = sdi_pkg::BUS_4BIT_ARG;
          kind    = sdi_pkg::RESP_SHORT;
        end
        default: begin
          // Final ACMD6 succeeded: 4-bit bus is selected.
          wide_d  = 1'b1;
          phase_d = sdi_pkg::PH_DONE;
          act     = sdi_pkg::ACT_OK;
        end
      endcase
    end

    // The result reports the state as it stands after this item.
    res_d.action        = act;
    res_d.cmd_index     = idx;
    res_d.cmd_arg       = arg;
    res_d.resp_kind     = kind;
    res_d.card_kind     = card_type_d;
    res_d.sector_total  = sector_d;
    res_d.card_address  = rca_d;
    res_d.clock_divider = (phase_d == sdi_pkg::PH_DONE) ? fast_div_q : ident_div_q;
    res_d.wide_bus      = wide_d;
  end

  // Sequencer state register, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sdi_pkg::PH_IDLE;
      v2_q        <= 1'b0;
      attempt_q   <= '0;
      card_type_q <= sdi_pkg::CARD_UNKNOWN;
      rca_q       <= '0;
      sector_q    <= '0;
      wide_q      <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      v2_q        <= v2_d;
      attempt_q   <= attempt_d;
      card_type_q <= card_type_d;
      rca_q       <= rca_d;
      sector_q    <= sector_d;
      wide_q      <= wide_d;
    end
  end

  // Output register: filled on an input transfer, emptied on an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A start transfer is always answered with CMD0.
  a_start_cmd0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.mode == sdi_pkg::MODE_START) |=>
      (out_valid_q && out_q.action == sdi_pkg::ACT_ISSUE &&
       out_q.cmd_index == sdi_pkg::CMD_GO_IDLE))
    else $error("start transfer not answered with CMD0");

  // The wide bus flag is only set once the sequence has finished ok.
  a_wide_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wide_q |-> (phase_q == sdi_pkg::PH_DONE))
    else $error("wide bus set outside the done phase");

  // A finished-error result reports an unknown card.
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == sdi_pkg::ACT_ERR) |->
      (out_q.card_kind == sdi_pkg::CARD_UNKNOWN))
    else $error("error result with a known card type");

  // An ignored outcome leaves the sequencer phase unchanged.
  a_ignore_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.mode == sdi_pkg::MODE_OUTCOME && !active) |=>
      $stable(phase_q))
    else $error("ignored outcome changed the phase");

endmodule

`default_nettype wire

>>> sim/sd_card_init_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SD-mode card identification sequencer.
// Drives start and outcome transfers, predicts each answer and checks it field by field.
// Depends on sdi_pkg, the channel interfaces in sdi_if.sv and the sequencer RTL.

module sd_card_init_sequencer_test;
  import sdi_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  sdi_in_if  in_ch ();
  sdi_out_if out_ch ();
  sdi_cfg_if cfg_ch ();

  sd_card_init_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Requests waiting to be driven and answers waiting to come back.
  in_item_t    queued_requests[$];
  out_item_t   expected_answers[$];

  // Idle percentages of the request side and the answer side.
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;

  // Shadow copy of the configuration registers.
  logic [7:0]  ident_div;
  logic [7:0]  fast_div;
  logic [7:0]  retry_limit;

  // Shadow copy of the sequencer state.
  phase_e      seq_phase;
  logic        v2_card;
  logic [7:0]  acmd41_tries;
  logic [1:0]  card_type_q;
  logic [15:0] rca_q;
  logic [32:0] sectors_q;
  logic        wide_q;

  // Bookkeeping for the report.
  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned answers_seen;
  int unsigned runs_started;
  int unsigned runs_ok;
  int unsigned runs_failed;
  int unsigned ignored_count;

  // Builds a command answer; status fields are filled in later.
  function automatic out_item_t issue_cmd(logic [5:0] idx, logic [31:0] arg, resp_kind_e kind);
    out_item_t ans;
    ans           = '0;
    ans.action    = ACT_ISSUE;
    ans.cmd_index = idx;
    ans.cmd_arg   = arg;
    ans.resp_kind = kind;
    return ans;
  endfunction

  // Advances the shadow sequencer by one request and returns the answer it must give.
  function automatic out_item_t sequencer_answer(in_item_t req);
    out_item_t   ans;
    logic [31:0] addr_arg;
    addr_arg = {rca_q, 16'h0000};
    ans      = '0;
    if (req.mode == MODE_START) begin
      card_type_q  = CARD_UNKNOWN;
      sectors_q    = '0;
      rca_q        = '0;
      wide_q       = 1'b0;
      v2_card      = 1'b0;
      acmd41_tries = '0;
      seq_phase    = PH_CMD0;
      runs_started++;
      ans = issue_cmd(CMD_GO_IDLE, '0, RESP_NONE);
    end else if (seq_phase < PH_CMD0 || seq_phase > PH_ACMD6) begin
      ans.action = ACT_IGNORE;
      ignored_count++;
    end else if (req.cmd_failed && seq_phase != PH_CMD8) begin
      // A failed command ends the run, except CMD8 where it means a V1 card.
      card_type_q = CARD_UNKNOWN;
      seq_phase   = PH_FAIL;
      ans.action  = ACT_ERR;
      runs_failed++;
    end else begin
      case (seq_phase)
        PH_CMD0: begin
          seq_phase = PH_CMD8;
          ans = issue_cmd(CMD_IF_COND, IF_COND_ARG, RESP_SHORT);
        end
        PH_CMD8: begin
          v2_card      = !req.cmd_failed && req.resp_word1 == IF_COND_ARG;
          acmd41_tries = '0;
          seq_phase    = PH_LOOP55;
          ans = issue_cmd(CMD_APP, '0, RESP_SHORT);
        end
        PH_LOOP55: begin
          seq_phase = PH_ACMD41;
          ans = issue_cmd(CMD_OP_COND, v2_card ? HCS_ARG : '0, RESP_SHORT);
        end
        PH_ACMD41: begin
          // Every judged attempt counts; reaching the limit is an error even if ready.
          if (acmd41_tries >= retry_limit) begin
            card_type_q = CARD_UNKNOWN;
            seq_phase   = PH_FAIL;
            ans.action  = ACT_ERR;
            runs_failed++;
          end else begin
            acmd41_tries = acmd41_tries + 8'd1;
            if (!req.resp_word1[31]) begin
              seq_phase = PH_LOOP55;
              ans = issue_cmd(CMD_APP, '0, RESP_SHORT);
            end else begin
              if (v2_card) card_type_q = req.resp_word1[30] ? CARD_V2_HC : CARD_V2_SC;
              else card_type_q = CARD_V1;
              seq_phase = PH_CMD2;
              ans = issue_cmd(CMD_ALL_CID, '0, RESP_LONG);
            end
          end
        end
        PH_CMD2: begin
          seq_phase = PH_CMD3;
          ans = issue_cmd(CMD_SEND_RCA, '0, RESP_SHORT);
        end
        PH_CMD3: begin
          rca_q     = req.resp_word1[31:16];
          seq_phase = PH_CMD9;
          ans = issue_cmd(CMD_SEND_CSD, {req.resp_word1[31:16], 16'h0000}, RESP_LONG);
        end
        PH_CMD9: begin
          // Capacity from the CSD size field, kept exact in 33 bits.
          if (card_type_q == CARD_V2_SC || card_type_q == CARD_V2_HC)
            sectors_q = ({11'd0, req.resp_word2[5:0], req.resp_word3[31:16]} + 33'd1) << 10;
          else
            sectors_q = ({21'd0, req.resp_word2[19:8]} + 33'd1) << 6;
          seq_phase = PH_CMD7;
          ans = issue_cmd(CMD_SELECT, addr_arg, RESP_SHORT);
        end
        PH_CMD7: begin
          seq_phase = PH_APP55;
          ans = issue_cmd(CMD_APP, addr_arg, RESP_SHORT);
        end
        PH_APP55: begin
          seq_phase = PH_ACMD6;
          ans = issue_cmd(CMD_SET_WIDTH, BUS_4BIT_ARG, RESP_SHORT);
        end
        default: begin
          wide_q     = 1'b1;
          seq_phase  = PH_DONE;
          ans.action = ACT_OK;
          runs_ok++;
        end
      endcase
    end
    ans.card_kind     = card_type_q;
    ans.sector_total  = sectors_q;
    ans.card_address  = rca_q;
    ans.clock_divider = (seq_phase == PH_DONE) ? fast_div : ident_div;
    ans.wide_bus      = wide_q;
    return ans;
  endfunction

  // Request driver: predicts on every accepted transfer, then picks the next request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_answers.push_back(sequencer_answer(in_ch.data));
        requests_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_ch.data  <= queued_requests.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reports one field mismatch; only the first ten are printed.
  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (mismatch_count < 10)
        $display("%t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
      mismatch_count++;
    end
  endtask

  // Checks one answer against the oldest prediction.
  task automatic check_answer(out_item_t got);
    out_item_t want;
    if (expected_answers.size() == 0) begin
      if (mismatch_count < 10)
        $display("%t: answer with nothing outstanding: %h", $realtime, got);
      mismatch_count++;
    end else begin
      want = expected_answers.pop_front();
      compare_field("action", 64'(want.action), 64'(got.action));
      compare_field("cmd_index", 64'(want.cmd_index), 64'(got.cmd_index));
      compare_field("cmd_arg", 64'(want.cmd_arg), 64'(got.cmd_arg));
      compare_field("resp_kind", 64'(want.resp_kind), 64'(got.resp_kind));
      compare_field("card_kind", 64'(want.card_kind), 64'(got.card_kind));
      compare_field("sector_total", 64'(want.sector_total), 64'(got.sector_total));
      compare_field("card_address", 64'(want.card_address), 64'(got.card_address));
      compare_field("clock_divider", 64'(want.clock_divider), 64'(got.clock_divider));
      compare_field("wide_bus", 64'(want.wide_bus), 64'(got.wide_bus));
    end
  endtask

  // Answer monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_answer(out_ch.data);
        answers_seen++;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  function automatic in_item_t mk(logic mode, logic failed, logic [31:0] w1,
                                  logic [31:0] w2, logic [31:0] w3);
    in_item_t it;
    it.mode       = mode;
    it.cmd_failed = failed;
    it.resp_word1 = w1;
    it.resp_word2 = w2;
    it.resp_word3 = w3;
    return it;
  endfunction

  function automatic in_item_t good_outcome();
    return mk(MODE_OUTCOME, 1'b0, $urandom, $urandom, $urandom);
  endfunction

  // Queues one identification run with random content; some runs are broken off.
  // Returns the number of requests queued.
  function automatic int unsigned queue_session(int unsigned not_ready);
    in_item_t    s[$];
    in_item_t    it;
    int unsigned cut;
    s.push_back(mk(MODE_START, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom));
    s.push_back(good_outcome());
    // CMD8: echo of the check pattern picks V2, a failure or other echo picks V1.
    it = good_outcome();
    case ($urandom_range(0, 3))
      0, 1:    it.resp_word1 = IF_COND_ARG;
      2:       it.cmd_failed = 1'b1;
      default: ;
    endcase
    s.push_back(it);
    repeat (not_ready) begin
      s.push_back(good_outcome());
      it = good_outcome();
      it.resp_word1[31] = 1'b0;
      s.push_back(it);
    end
    s.push_back(good_outcome());
    it = good_outcome();
    it.resp_word1[31] = 1'b1;
    s.push_back(it);
    repeat (6) s.push_back(good_outcome());
    // Break the run with a failure or a restart somewhere after the start.
    if ($urandom_range(0, 99) < 20) begin
      cut = $urandom_range(1, s.size() - 1);
      if ($urandom_range(0, 3) == 0) s[cut].mode = MODE_START;
      else s[cut].cmd_failed = 1'b1;
      while (s.size() > cut + 1) void'(s.pop_back());
    end
    foreach (s[i]) queued_requests.push_back(s[i]);
    return s.size();
  endfunction

  // Fills the queue with runs, a little noise in between, until the target is met.
  task automatic queue_random_phase(int unsigned target);
    int unsigned filled;
    int unsigned pick;
    int unsigned tries;
    filled = 0;
    while (filled < target) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3))
          queued_requests.push_back(mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       $urandom, $urandom, $urandom));
      pick = $urandom_range(0, 19);
      if (pick == 0) tries = retry_limit;
      else if (pick == 1 && retry_limit != 0) tries = retry_limit - 1;
      else tries = $urandom_range(0, 3);
      filled += queue_session(tries);
    end
  endtask

  // Register write on the configuration channel; the shadow follows at the transfer.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_IDENT_DIV: ident_div   = val;
      CFG_FAST_DIV:  fast_div    = val;
      CFG_RETRY_LIM: retry_limit = val;
      default: ;
    endcase
  endtask

  // Waits until every request is sent and every answer is back, then a little longer.
  // The check runs at the falling edge, after the driver's updates have settled.
  task automatic wait_for_quiet();
    while (queued_requests.size() != 0 || in_ch.valid || expected_answers.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Main sequence: directed runs, then three random phases with different settings.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.data        = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.value      = '0;
    rst_ni            = 1'b0;
    sender_idle_pct   = 10;
    receiver_idle_pct = 63;
    ident_div         = IDENT_DIV_RST;
    fast_div          = FAST_DIV_RST;
    retry_limit       = RETRY_LIM_RST;
    seq_phase         = PH_IDLE;
    v2_card           = 1'b0;
    acmd41_tries      = '0;
    card_type_q       = CARD_UNKNOWN;
    rca_q             = '0;
    sectors_q         = '0;
    wide_q            = 1'b0;
    mismatch_count    = 0;
    requests_sent     = 0;
    answers_seen      = 0;
    runs_started      = 0;
    runs_ok           = 0;
    runs_failed       = 0;
    ignored_count     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Outcome while idle is ignored.
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b1, '1, '1, '1));
    // High-capacity V2 card with the largest size field, then an outcome after done.
    queued_requests.push_back(mk(MODE_START, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, IF_COND_ARG, '1, '1));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, 32'hC000_0000, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '1, '1, '1));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, 32'hFFFF_0000, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, 32'h0000_003F, 32'hFFFF_0000));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b1, '0, '0, '0));
    // V1 card via a failed CMD8, not ready once, then restarted while busy.
    queued_requests.push_back(mk(MODE_START, 1'b1, '1, '1, '1));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b1, IF_COND_ARG, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, 32'h7FFF_FFFF, '0, '0));
    queued_requests.push_back(mk(MODE_START, 1'b0, '0, '0, '0));
    // CMD0 failure ends the run; later outcomes are ignored.
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b1, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    wait_for_quiet();

    // A retry limit of zero fails on the first judged ACMD41, even when ready.
    write_register(CFG_RETRY_LIM, 8'd0);
    queued_requests.push_back(mk(MODE_START, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, IF_COND_ARG, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, '0, '0, '0));
    queued_requests.push_back(mk(MODE_OUTCOME, 1'b0, 32'hC000_0000, '0, '0));
    wait_for_quiet();

    // Sender mostly busy, receiver often stalling; extreme dividers, retry limit of one.
    write_register(CFG_IDENT_DIV, 8'd0);
    write_register(CFG_FAST_DIV, 8'd255);
    write_register(CFG_RETRY_LIM, 8'd1);
    queue_random_phase(325);
    wait_for_quiet();

    // Roles swapped; opposite dividers, loosest limit.
    sender_idle_pct   = 63;
    receiver_idle_pct = 10;
    write_register(CFG_IDENT_DIV, 8'd255);
    write_register(CFG_FAST_DIV, 8'd0);
    write_register(CFG_RETRY_LIM, 8'd255);
    queue_random_phase(325);
    wait_for_quiet();

    // Full rate on both sides with random settings.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_register(CFG_IDENT_DIV, 8'($urandom_range(0, 255)));
    write_register(CFG_FAST_DIV, 8'($urandom_range(0, 255)));
    write_register(CFG_RETRY_LIM, 8'($urandom_range(2, 8)));
    queue_random_phase(325);
    wait_for_quiet();

    $display("Sent %0d requests and checked %0d answers under three idle patterns.",
             requests_sent, answers_seen);
    $display("Runs started %0d: %0d finished ok, %0d finished with error; %0d ignored.",
             runs_started, runs_ok, runs_failed, ignored_count);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing answers.
  initial begin
    #2_000_000;
    $display("Timed out with %0d answers outstanding.", expected_answers.size());
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sd_card_init_sequencer.f
hw/rtl/sdi_pkg.sv
hw/rtl/sdi_if.sv
hw/rtl/sd_card_init_sequencer.sv
sim/sd_card_init_sequencer_test.sv
